/* src/spix_pkg.sv */
// Shared widths, constants and types for the spiral index to point unit.
package spix_pkg;

  localparam int INDEX_BITS = 20;
  localparam int COORD_W    = 11;
  localparam int CELLS      = (INDEX_BITS + 1) / 2;
  localparam int SQ_W       = 2 * CELLS;
  localparam int ROOT_W     = CELLS;
  localparam int REM_W      = CELLS + 1;
  localparam int CALC_W     = (CELLS + 3 > COORD_W) ? CELLS + 3 : COORD_W;

  typedef struct packed {
    logic            valid;
    logic [SQ_W-1:0] rem;
    logic [SQ_W-1:0] res;
  } chain_word_t;

  function automatic logic [SQ_W-1:0] cell_bit(input int k);
    logic [SQ_W-1:0] b;
    b = '0;
    b[SQ_W - 2 - 2 * k] = 1'b1;
    return b;
  endfunction

endpackage

/* src/spix_cell.sv */
// One digit step of the square root chain, registered.
module spix_cell (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [spix_pkg::SQ_W-1:0] bit_w,
  input  spix_pkg::chain_word_t   prev,
  output spix_pkg::chain_word_t   cur
);
  import spix_pkg::*;

  logic [SQ_W:0]   trial;
  logic            take;
  logic [SQ_W-1:0] rem_next;
  logic [SQ_W-1:0] res_next;

  always_comb begin
    trial = {1'b0, prev.res} + {1'b0, bit_w};
    take  = {1'b0, prev.rem} >= trial;
    if (take) begin
      rem_next = prev.rem - trial[SQ_W-1:0];
      res_next = (prev.res >> 1) + bit_w;
    end else begin
      rem_next = prev.rem;
      res_next = prev.res >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur.valid <= 1'b0;
    end else begin
      cur.valid <= prev.valid;
    end
    cur.rem <= rem_next;
    cur.res <= res_next;
  end

endmodule

/* src/spix_map.sv */
// Ring edge mapping from root and remainder, with hold and output registers.
module spix_map (
  input  logic                             clk,
  input  logic                             rst,
  input  spix_pkg::chain_word_t            tail,
  output logic                             busy,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [spix_pkg::COORD_W-1:0] coord_x,
  output logic signed [spix_pkg::COORD_W-1:0] coord_z
);
  import spix_pkg::*;

  logic              pend_valid;
  logic [ROOT_W-1:0] pend_root;
  logic [REM_W-1:0]  pend_rem;
  logic              move;

  logic signed [CALC_W-1:0] r_ext;
  logic signed [CALC_W-1:0] rem_ext;
  logic signed [CALC_W-1:0] rr;
  logic signed [CALC_W-1:0] d;
  logic signed [CALC_W-1:0] h;
  logic signed [CALC_W-1:0] x_calc;
  logic signed [CALC_W-1:0] z_calc;
  logic                     up;

  assign move = pend_valid && (!out_valid || !out_stall);
  assign busy = pend_valid;

  always_comb begin
    r_ext   = CALC_W'(pend_root);
    rem_ext = CALC_W'(pend_rem);
    up      = rem_ext > r_ext;
    rr      = up ? r_ext + CALC_W'(1) : r_ext;
    d       = up ? rem_ext - ((r_ext <<< 1) + CALC_W'(1)) : rem_ext;
    if (!rr[0]) begin
      h = rr >>> 1;
      if (!up) begin
        x_calc = h;
        z_calc = d - h;
      end else begin
        x_calc = d + h;
        z_calc = -h;
      end
    end else begin
      h = (rr + CALC_W'(1)) >>> 1;
      if (!up) begin
        x_calc = -h;
        z_calc = h - CALC_W'(1) - d;
      end else begin
        x_calc = -h - d;
        z_calc = h - CALC_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (tail.valid) begin
        pend_valid <= 1'b1;
      end else if (move) begin
        pend_valid <= 1'b0;
      end
      if (move) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
    if (tail.valid) begin
      pend_root <= tail.res[ROOT_W-1:0];
      pend_rem  <= tail.rem[REM_W-1:0];
    end
    if (move) begin
      coord_x <= x_calc[COORD_W-1:0];
      coord_z <= z_calc[COORD_W-1:0];
    end
  end

  a_pend_drains: assert property (@(posedge clk) disable iff (rst)
    pend_valid && !out_valid |=> !pend_valid)
    else $error("pending word not moved to free output");

  a_tail_loads: assert property (@(posedge clk) disable iff (rst)
    tail.valid |=> pend_valid)
    else $error("chain word lost");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    tail.valid |-> !pend_valid)
    else $error("chain word arrived while pending word held");

endmodule

/* src/spiral_index_to_point_unit.sv */
// Top level: square spiral index to grid point, square root cell chain and mapping.
// An accepted index passes the ten root cells, then the hold register and the output
// register when the output is free. One index is in the chain or the hold register at
// a time; the next index enters only once the hold register has passed its word on.
// A waiting result does not block the next index from entering the chain.
// Reset (rst, synchronous, active high) empties the chain and the output.
module spiral_index_to_point_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [spix_pkg::INDEX_BITS-1:0]     spiral_index,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [spix_pkg::COORD_W-1:0] coord_x,
  output logic signed [spix_pkg::COORD_W-1:0] coord_z
);
  import spix_pkg::*;

  chain_word_t head;
  chain_word_t chain [CELLS];
  logic [CELLS-1:0] chain_valid;
  logic             map_busy;
  logic             accept;

  assign accept     = in_valid && !in_stall;
  assign head.valid = accept;
  assign head.rem   = SQ_W'(spiral_index);
  assign head.res   = '0;

  for (genvar k = 0; k < CELLS; k++) begin : g_cell
    localparam logic [SQ_W-1:0] BitK = cell_bit(k);
    if (k == 0) begin : g_first
      spix_cell u_cell (
        .clk  (clk),
        .rst  (rst),
        .bit_w(BitK),
        .prev (head),
        .cur  (chain[k])
      );
    end else begin : g_rest
      spix_cell u_cell (
        .clk  (clk),
        .rst  (rst),
        .bit_w(BitK),
        .prev (chain[k-1]),
        .cur  (chain[k])
      );
    end
    assign chain_valid[k] = chain[k].valid;
  end

  spix_map u_map (
    .clk      (clk),
    .rst      (rst),
    .tail     (chain[CELLS-1]),
    .busy     (map_busy),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .coord_x  (coord_x),
    .coord_z  (coord_z)
  );

  assign in_stall = (|chain_valid) || map_busy;

  a_single_word: assert property (@(posedge clk) disable iff (rst)
    $onehot0({chain_valid, map_busy}))
    else $error("more than one word in flight");

  a_enter_chain: assert property (@(posedge clk) disable iff (rst)
    accept |=> chain_valid[0])
    else $error("accepted word missing from first cell");

  a_chain_advance: assert property (@(posedge clk) disable iff (rst)
    chain_valid[CELLS-1] |=> map_busy && in_stall)
    else $error("word left chain without being held");

endmodule

/* tb/spiral_point_checker.sv */
// Checker for the spiral index to point unit: predicts each point and compares results.
module spiral_point_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic [spix_pkg::INDEX_BITS-1:0]     spiral_index,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic signed [spix_pkg::COORD_W-1:0] coord_x,
  input  logic signed [spix_pkg::COORD_W-1:0] coord_z,
  output int                                  errors,
  output int                                  pending
);
  import spix_pkg::*;

  typedef struct {
    logic [INDEX_BITS-1:0]     idx;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] z;
  } spiral_point_t;

  spiral_point_t expected_points [$];

  initial begin
    errors  = 0;
    pending = 0;
  end

  function automatic spiral_point_t spiral_point(input logic [INDEX_BITS-1:0] idx);
    longint n, r, cand, d, h, px, pz;
    spiral_point_t p;
    n = idx;
    r = 0;
    for (int b = CELLS - 1; b >= 0; b--) begin
      cand = r | (longint'(1) << b);
      if (cand * cand <= n) r = cand;
    end
    // pick the nearer of the two neighboring squares
    if (n - r * r > (r + 1) * (r + 1) - n) r = r + 1;
    d = n - r * r;
    if (r[0] == 1'b0) begin
      h = r / 2;
      if (d >= 0) begin
        px = h;
        pz = d - h;
      end else begin
        px = d + h;
        pz = -h;
      end
    end else begin
      h = (r + 1) / 2;
      if (d >= 0) begin
        px = -h;
        pz = h - 1 - d;
      end else begin
        px = -h - d;
        pz = h - 1;
      end
    end
    p.idx = idx;
    p.x   = px[COORD_W-1:0];
    p.z   = pz[COORD_W-1:0];
    return p;
  endfunction

  always @(posedge clk) begin : watch
    int fails;
    spiral_point_t want;
    fails = 0;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_points.size() == 0) begin
          fails++;
          $display("%0t: unexpected word x=%0d z=%0d", $time, coord_x, coord_z);
        end else begin
          want = expected_points.pop_front();
          if (coord_x !== want.x) begin
            fails++;
            $display("%0t: index %0d coord_x expected %0d actual %0d",
                     $time, want.idx, want.x, coord_x);
          end
          if (coord_z !== want.z) begin
            fails++;
            $display("%0t: index %0d coord_z expected %0d actual %0d",
                     $time, want.idx, want.z, coord_z);
          end
        end
      end
      if (in_valid && !in_stall)
        expected_points.insert(expected_points.size(), spiral_point(spiral_index));
    end
    errors  <= errors + fails;
    pending <= expected_points.size();
  end

endmodule

/* tb/tb_spiral_index_to_point_unit.sv */
// Testbench top for the spiral index to point unit: stimulus, stalls and verdict.
module tb_spiral_index_to_point_unit;
  import spix_pkg::*;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [INDEX_BITS-1:0]     spiral_index = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic signed [COORD_W-1:0] coord_x;
  logic signed [COORD_W-1:0] coord_z;
  int                        errors;
  int                        pending;
  bit                        calm = 1'b0;
  int                        stall_left = 0;

  spiral_index_to_point_unit dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .spiral_index (spiral_index),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .coord_x      (coord_x),
    .coord_z      (coord_z)
  );

  spiral_point_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .spiral_index (spiral_index),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .coord_x      (coord_x),
    .coord_z      (coord_z),
    .errors       (errors),
    .pending      (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // draw a wait after each accepted word and spend it while the next word is valid
  always @(posedge clk) begin : sink
    int wait_cycles;
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (out_valid && !out_stall) begin
      wait_cycles = calm ? 0 : $urandom_range(0, 5);
      stall_left <= wait_cycles;
      out_stall  <= (wait_cycles != 0);
    end else if (out_valid && stall_left > 1) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (out_valid) begin
      stall_left <= 0;
      out_stall  <= 1'b0;
    end
  end

  task automatic send_index(input logic [INDEX_BITS-1:0] v);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    spiral_index <= v;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [INDEX_BITS-1:0] near_square_index();
    longint r, v;
    r = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 1024);
    v = r * r + longint'($urandom_range(0, 2 * r)) - r;
    if (v < 0) v = 0;
    if (v > (longint'(1) << INDEX_BITS) - 1) v = (longint'(1) << INDEX_BITS) - 1;
    return v[INDEX_BITS-1:0];
  endfunction

  initial begin : stimulus
    logic [INDEX_BITS-1:0] corners [$];
    corners = '{0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 12, 13, 21, 25, 30, 31,
                1046528, 1046529, 1047552, 1047553, 1048575,
                20'h55555, 20'hAAAAA, 20'h80000};
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (corners[i]) send_index(corners[i]);
    drain();
    for (int i = 0; i < 500; i++) begin
      calm = (i >= 150 && i < 200) || (i >= 350 && i < 400);
      if (i == 250) drain();
      if ($urandom_range(0, 3) == 0) send_index(INDEX_BITS'($urandom));
      else send_index(near_square_index());
    end
    calm = 1'b0;
    drain();
    repeat (30) @(posedge clk);
    if (errors == 0) begin
      $display("spiral_index_to_point_unit: match");
    end else begin
      $display("spiral_index_to_point_unit: mismatch");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("spiral_index_to_point_unit: mismatch");
    $finish;
  end

endmodule

/* sim.f */
src/spix_pkg.sv
src/spix_cell.sv
src/spix_map.sv
src/spiral_index_to_point_unit.sv
tb/spiral_point_checker.sv
tb/tb_spiral_index_to_point_unit.sv
